### rtl/core/brb_pkg.sv
// shared types and constants for the bulk ring buffer
package brb_pkg;

   localparam int unsigned BRB_DEPTH     = 16;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned CNT_W         = 5;
   localparam int unsigned MAX_BATCH     = 16;
   localparam int unsigned QDEPTH        = 2;
   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [CNT_W-1:0]          count;
      logic signed [DATA_W-1:0]  value;
   } item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  value_res;
      logic                      ok;
      logic                      last;
      logic [CNT_W-1:0]          occupied;
   } result_type;

endpackage

### rtl/core/brb_front.sv
// input side: classifies items and holds them in a short queue
module brb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [brb_pkg::CNT_W-1:0]      req_count,
   input  logic signed [brb_pkg::DATA_W-1:0] req_value,
   output logic                           q_valid,
   input  logic                           q_ready,
   output brb_pkg::item_type              q_item
);
   import brb_pkg::*;

   localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(QDEPTH + 1);

   item_type            q_ff [QDEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   item_type            entry;
   logic                push_en, pop_en;

   // pop requests that can never succeed are marked here
   always_comb begin
      entry.count = req_count;
      entry.value = req_value;
      if (!req_func) begin
         entry.op = OP_PUSH;
      end else if (req_count == '0 || 32'(req_count) > MAX_BATCH) begin
         entry.op = OP_REJECT;
      end else begin
         entry.op = OP_POP;
      end
   end

   assign req_ready = (32'(fill_ff) < QDEPTH);
   assign q_valid   = (fill_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];
   assign push_en   = req_valid && req_ready;
   assign pop_en    = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_en) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### rtl/core/brb_back.sv
// execution side: ring storage, batch bookkeeping and the result register
module brb_back #(
   parameter int unsigned DEPTH = brb_pkg::BRB_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic [brb_pkg::CNT_W-1:0]  eff_cap,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  brb_pkg::item_type          q_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output brb_pkg::result_type        rsp
);
   import brb_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);

   logic signed [DATA_W-1:0] slots_mem [DEPTH];

   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   committed_ff, committed_in;
   logic [CNT_W-1:0]   reserved_ff, reserved_in;
   logic [CNT_W-1:0]   batch_rem_ff, batch_rem_in;
   logic               refused_ff, refused_in;
   logic [CNT_W-1:0]   pop_rem_ff, pop_rem_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     ok_ff, ok_in;
   logic                     last_ff, last_in;
   logic [CNT_W-1:0]         occ_ff, occ_in;
   logic                     data_sel_ff, data_sel_in;
   logic signed [DATA_W-1:0] rd_data_ff;

   logic               out_free, take, load, mem_we, mem_rd;
   logic               first, refused_now;
   logic [CNT_W-1:0]   n, rem_after, res_new;
   logic [CNT_W:0]     res_sum;

   function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i,
                                            input logic [CNT_W-1:0] cap);
      logic [IDX_W-1:0] r;
      r = (32'(i) + 32'd1 >= 32'(cap)) ? '0 : i + 1'b1;
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_ready  = out_free && (pop_rem_ff == '0);
   assign take     = q_valid && q_ready;

   // push bookkeeping, evaluated for the item at the queue head
   always_comb begin
      first       = (batch_rem_ff == '0);
      n           = (q_item.count == '0) ? CNT_W'(1) : q_item.count;
      res_sum     = {1'b0, reserved_ff} + {1'b0, n};
      refused_now = first ? (res_sum > {1'b0, eff_cap}) : refused_ff;
      rem_after   = (first ? n : batch_rem_ff) - 1'b1;
      res_new     = (first && !refused_now) ? res_sum[CNT_W-1:0] : reserved_ff;
   end

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      committed_in = committed_ff;
      reserved_in  = reserved_ff;
      batch_rem_in = batch_rem_ff;
      refused_in   = refused_ff;
      pop_rem_in   = pop_rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ok_in        = ok_ff;
      last_in      = last_ff;
      occ_in       = occ_ff;
      data_sel_in  = data_sel_ff;
      load         = 1'b0;
      mem_we       = 1'b0;
      mem_rd       = 1'b0;
      if (pop_rem_ff != '0 && out_free) begin
         // rest of a pop burst, one word per cycle while the result register is free
         load        = 1'b1;
         mem_rd      = 1'b1;
         rd_idx_in   = nxt(rd_idx_ff, eff_cap);
         pop_rem_in  = pop_rem_ff - 1'b1;
         ok_in       = 1'b1;
         last_in     = (pop_rem_ff == CNT_W'(1));
         occ_in      = committed_ff;
         data_sel_in = 1'b1;
      end else if (take) begin
         load = 1'b1;
         case (q_item.op)
            OP_PUSH: begin
               batch_rem_in = rem_after;
               reserved_in  = res_new;
               if (!refused_now) begin
                  mem_we    = 1'b1;
                  wr_idx_in = nxt(wr_idx_ff, eff_cap);
               end
               if (rem_after == '0) begin
                  refused_in = 1'b0;
                  if (!refused_now) begin
                     committed_in = res_new;
                  end
               end else begin
                  refused_in = refused_now;
               end
               ok_in       = !refused_now;
               last_in     = 1'b1;
               occ_in      = committed_in;
               data_sel_in = 1'b0;
            end
            OP_POP: begin
               if (q_item.count > committed_ff) begin
                  ok_in       = 1'b0;
                  last_in     = 1'b1;
                  occ_in      = committed_ff;
                  data_sel_in = 1'b0;
               end else begin
                  committed_in = committed_ff - q_item.count;
                  reserved_in  = reserved_ff - q_item.count;
                  mem_rd       = 1'b1;
                  rd_idx_in    = nxt(rd_idx_ff, eff_cap);
                  pop_rem_in   = q_item.count - 1'b1;
                  ok_in        = 1'b1;
                  last_in      = (q_item.count == CNT_W'(1));
                  occ_in       = committed_in;
                  data_sel_in  = 1'b1;
               end
            end
            default: begin
               ok_in       = 1'b0;
               last_in     = 1'b1;
               occ_in      = committed_ff;
               data_sel_in = 1'b0;
            end
         endcase
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // ring state; a capacity write empties the ring
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         committed_ff <= '0;
         reserved_ff  <= '0;
         batch_rem_ff <= '0;
         refused_ff   <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         committed_ff <= committed_in;
         reserved_ff  <= reserved_in;
         batch_rem_ff <= batch_rem_in;
         refused_ff   <= refused_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_rem_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pop_rem_ff   <= pop_rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      last_ff     <= last_in;
      occ_ff      <= occ_in;
      data_sel_ff <= data_sel_in;
   end

   // read data register doubles as the output data stage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_mem[wr_idx_ff] <= q_item.value;
      end
      if (mem_rd) begin
         rd_data_ff <= slots_mem[rd_idx_ff];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp.value_res = data_sel_ff ? rd_data_ff : '0;
   assign rsp.ok        = ok_ff;
   assign rsp.last      = last_ff;
   assign rsp.occupied  = occ_ff;

endmodule

### rtl/core/bulk_ring_buffer.sv
// top level of the bulk ring buffer: register port, front and back halves
// Ring-buffer fifo with all-or-nothing batch push and batch pop.
// req channel: one item per push element (func 0; count on the first
// element of a batch gives its length) or one item per pop request
// (func 1, count = words wanted). rsp channel: each push element gives one
// status item; a pop gives count data items, the final one marked by last,
// or a single failure item. Every result carries the committed occupancy.
// The first result of an item is registered when the back half takes the
// item. A successful pop reads its count words through the one read port
// of the slot memory and takes no new item until the last word is read;
// after a push element or a failed pop the next item can follow back to back.
// A two-entry queue sits between the input side and the back half, and the
// result register takes a new item as the old one leaves, so a stalled
// receiver holds the current result and fills the queue before req_ready
// drops. Reset empties the ring and sets ring_capacity to 16; writing
// ring_capacity (offset 0) also empties the ring. Slot contents are kept.
module bulk_ring_buffer #(
   parameter int unsigned DEPTH = brb_pkg::BRB_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [brb_pkg::CNT_W-1:0]         req_count,
   input  logic signed [brb_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [brb_pkg::DATA_W-1:0] rsp_value_res,
   output logic                              rsp_ok,
   output logic                              rsp_last,
   output logic [brb_pkg::CNT_W-1:0]         rsp_occupied,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import brb_pkg::*;

   localparam logic REG_CAPACITY = 1'b0;

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] eff_cap;
   logic             cap_wr;
   logic             q_valid, q_ready;
   item_type         q_item;
   result_type       rsp_res;

   assign pready = 1'b1;
   assign cap_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
   assign cap_in = cap_wr ? pwdata[CNT_W-1:0] : cap_ff;
   assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // zero acts as one slot, anything past the storage as the full storage
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > DEPTH) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
   end

   brb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_count (req_count),
      .req_value (req_value),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   brb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clear     (cap_wr),
      .eff_cap   (eff_cap),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_res)
   );

   assign rsp_value_res = rsp_res.value_res;
   assign rsp_ok        = rsp_res.ok;
   assign rsp_last      = rsp_res.last;
   assign rsp_occupied  = rsp_res.occupied;

   // status and failure items never carry data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value_res == '0)
      else $error("failure item carries data");

   // only pop data items can be unmarked
   a_unmarked_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_ok)
      else $error("unmarked item is not pop data");

   // a pop burst runs back to back with a fixed occupancy
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_occupied))
      else $error("pop burst broken");

endmodule
